>>> rtl/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants of the terminal line editor
// key codes, result kinds, cell commands and default settings
// ----------------------------------------------------------------------------
`default_nettype none

package tle_pkg;

  // counts, cursor and view offset are always 7 bits wide
  localparam int CNT_W = 7;
  localparam int LINE_CAP_DEF = 64;
  localparam logic [7:0] DW_RESET = 8'd79;

  // result kinds
  localparam logic [2:0] KIND_STATUS = 3'd0;
  localparam logic [2:0] KIND_CHAR   = 3'd1;
  localparam logic [2:0] KIND_EMPTY  = 3'd2;
  localparam logic [2:0] KIND_EOF    = 3'd3;
  localparam logic [2:0] KIND_INTR   = 3'd4;

  // key codes
  localparam logic [7:0] KEY_CTRL_A = 8'd1;
  localparam logic [7:0] KEY_CTRL_C = 8'd3;
  localparam logic [7:0] KEY_CTRL_D = 8'd4;
  localparam logic [7:0] KEY_CTRL_E = 8'd5;
  localparam logic [7:0] KEY_BS     = 8'd8;
  localparam logic [7:0] KEY_CTRL_K = 8'd11;
  localparam logic [7:0] KEY_CTRL_L = 8'd12;
  localparam logic [7:0] KEY_ENTER  = 8'd13;
  localparam logic [7:0] KEY_CTRL_N = 8'd14;
  localparam logic [7:0] KEY_CTRL_P = 8'd16;
  localparam logic [7:0] KEY_CTRL_T = 8'd20;
  localparam logic [7:0] KEY_CTRL_U = 8'd21;
  localparam logic [7:0] KEY_CTRL_W = 8'd23;
  localparam logic [7:0] KEY_ESC    = 8'd27;
  localparam logic [7:0] KEY_LBRACK = 8'd91;
  localparam logic [7:0] KEY_C      = 8'd67;
  localparam logic [7:0] KEY_D      = 8'd68;
  localparam logic [7:0] KEY_DEL    = 8'd127;

  // command broadcast along the cell row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_SHL
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [CNT_W-1:0] pos;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/tle_cell.sv
// ----------------------------------------------------------------------------
// tle_cell: one character cell of the line row
// holds one character and takes it from the key or a neighbor on insert, from a neighbor on delete or drain
// ----------------------------------------------------------------------------
`default_nettype none

module tle_cell import tle_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic       clk_i,
  input  wire cell_cmd_t  cmd_i,
  input  wire logic [7:0] key_i,
  input  wire logic [7:0] left_i,
  input  wire logic [7:0] right_i,
  output logic [7:0]      data_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [7:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      CELL_INS: begin
        if (MyIdx > cmd_i.pos) begin
          data_d = left_i;
        end else if (MyIdx == cmd_i.pos) begin
          data_d = key_i;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= cmd_i.pos) begin
          data_d = right_i;
        end
      end
      CELL_SHL: data_d = right_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> rtl/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_editor: line editor for raw keyboard bytes with arrow keys
// keeps an editable line in a row of character cells, with cursor and view
// ----------------------------------------------------------------------------
// output: a key's status word is registered and valid in the cycle after the key is taken
// throughput: one key per cycle while the output word is taken and no line is draining;
//   after Enter on a non-empty line, the cell row drains one character per cycle
//   into cell 0 while the output word is taken; cell 0 feeds the output register
// reset: cursor, length, view, escape stage and width register (79) are set
//   at once; the cell contents are not reset and need no clearing pass
`default_nettype none

module terminal_line_editor import tle_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAP_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration write channel
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [7:0]       cfg_wdata_i,
  // key input channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       key_byte_i,
  // result output channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [2:0]            kind_o,
  output logic [7:0]            line_char_o,
  output logic [CNT_W-1:0]      cursor_o,
  output logic [CNT_W-1:0]      length_o,
  output logic [CNT_W-1:0]      view_offset_o,
  output logic                  last_o
);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // escape sequence stages
  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_OPEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;
  localparam logic [1:0] ESC_SKIP = 2'd3;

  localparam logic [CNT_W-1:0] Cap = CNT_W'(LINE_CAPACITY);

  // view follows the cursor one step when it runs past the visible width
  function automatic logic [CNT_W-1:0] scroll(input logic [CNT_W-1:0] cur,
                                               input logic [CNT_W-1:0] view,
                                               input logic [7:0]       width);
    logic [CNT_W-1:0] diff;
    diff = cur - view;
    return ({1'b0, diff} > width) ? view + 1'b1 : view;
  endfunction

  logic             state_q, state_d;
  logic [1:0]       esc_q, esc_d;
  logic [CNT_W-1:0] cursor_q, cursor_d;
  logic [CNT_W-1:0] length_q, length_d;
  logic [CNT_W-1:0] view_q, view_d;
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic [7:0]       width_q;

  logic             out_valid_q, out_valid_d;
  logic [2:0]       kind_q;
  logic [7:0]       char_q;
  logic [CNT_W-1:0] ocur_q, olen_q, oview_q;
  logic             last_q;

  logic             slot_free;
  logic             in_acc;
  logic             res_load;
  logic [2:0]       res_kind;
  logic [7:0]       res_char;
  logic             res_last;
  logic [CNT_W-1:0] cur_tmp;
  cell_cmd_t        cmd;

  // cell row, cell 0 is the head of the line
  logic [7:0] cell_data [LINE_CAPACITY];

  // output slot frees up when empty or when its word is taken this cycle
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && slot_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // the user writes configuration only while idle, the block does not enforce it; always ready
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d  = state_q;
    esc_d    = esc_q;
    cursor_d = cursor_q;
    length_d = length_q;
    view_d   = view_q;
    rd_cnt_d = rd_cnt_q;
    res_load = 1'b0;
    res_kind = KIND_STATUS;
    res_char = 8'd0;
    res_last = 1'b1;
    cur_tmp  = cursor_q;
    cmd.op   = CELL_HOLD;
    cmd.pos  = '0;

    if (in_acc) begin
      res_load = 1'b1;
      unique case (esc_q)
        ESC_OPEN: begin
          esc_d = (key_byte_i == KEY_LBRACK) ? ESC_CSI : ESC_SKIP;
        end
        ESC_CSI: begin
          esc_d = ESC_IDLE;
          if (key_byte_i == KEY_C) begin
            // right arrow
            cur_tmp  = (cursor_q < length_q) ? cursor_q + 1'b1 : cursor_q;
            cursor_d = cur_tmp;
            view_d   = scroll(cur_tmp, view_q, width_q);
          end else if (key_byte_i == KEY_D) begin
            // left arrow
            cur_tmp  = (cursor_q != '0) ? cursor_q - 1'b1 : cursor_q;
            cursor_d = cur_tmp;
            view_d   = (cur_tmp < view_q) ? view_q - 1'b1 : view_q;
          end
        end
        ESC_SKIP: begin
          esc_d = ESC_IDLE;
        end
        default: begin
          case (key_byte_i) inside
            KEY_ENTER: begin
              cursor_d = '0;
              length_d = '0;
              view_d   = '0;
              if (length_q == '0) begin
                res_kind = KIND_EMPTY;
              end else begin
                // characters follow from the drain sequence
                res_load = 1'b0;
                rd_cnt_d = length_q;
                state_d  = ST_READ;
              end
            end
            KEY_BS, KEY_DEL: begin
              if (cursor_q != '0) begin
                cmd.op   = CELL_DEL;
                cmd.pos  = cursor_q - 1'b1;
                cursor_d = cursor_q - 1'b1;
                length_d = length_q - 1'b1;
                view_d   = (view_q != '0) ? view_q - 1'b1 : view_q;
              end
            end
            KEY_CTRL_C: begin
              cursor_d = '0;
              length_d = '0;
              view_d   = '0;
              res_kind = KIND_INTR;
            end
            KEY_CTRL_D: begin
              if (length_q == '0) begin
                res_kind = KIND_EOF;
              end
            end
            KEY_CTRL_U: begin
              cursor_d = '0;
              length_d = '0;
              view_d   = '0;
            end
            KEY_ESC: begin
              esc_d = ESC_OPEN;
            end
            KEY_CTRL_A, KEY_CTRL_E, KEY_CTRL_K, KEY_CTRL_L,
            KEY_CTRL_N, KEY_CTRL_P, KEY_CTRL_T, KEY_CTRL_W: begin
              // no-op keys
            end
            default: begin
              // insert at the cursor, a full line ignores the key
              if (length_q < Cap) begin
                cmd.op   = CELL_INS;
                cmd.pos  = cursor_q;
                cur_tmp  = cursor_q + 1'b1;
                cursor_d = cur_tmp;
                length_d = length_q + 1'b1;
                view_d   = scroll(cur_tmp, view_q, width_q);
              end
            end
          endcase
        end
      endcase
    end else if ((state_q == ST_READ) && slot_free) begin
      // drain: cell 0 goes out, the row moves one place toward the head
      res_load = 1'b1;
      res_kind = KIND_CHAR;
      res_char = cell_data[0];
      res_last = (rd_cnt_q == CNT_W'(1));
      cmd.op   = CELL_SHL;
      rd_cnt_d = rd_cnt_q - 1'b1;
      if (res_last) begin
        state_d = ST_IDLE;
      end
    end
  end

  assign out_valid_d = res_load || (out_valid_q && out_stall_i);

  // cell row
  for (genvar g = 0; g < LINE_CAPACITY; g++) begin : g_cell
    logic [7:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = 8'd0;
    end else begin : g_body_l
      assign left_w = cell_data[g-1];
    end
    if (g == LINE_CAPACITY - 1) begin : g_tail
      assign right_w = 8'd0;
    end else begin : g_body_r
      assign right_w = cell_data[g+1];
    end
    tle_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .key_i   (key_byte_i),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      esc_q       <= ESC_IDLE;
      cursor_q    <= '0;
      length_q    <= '0;
      view_q      <= '0;
      rd_cnt_q    <= '0;
      width_q     <= DW_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      esc_q       <= esc_d;
      cursor_q    <= cursor_d;
      length_q    <= length_d;
      view_q      <= view_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        width_q <= cfg_wdata_i;
      end
    end
  end

  // output word, loaded only when the slot is free
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      kind_q  <= res_kind;
      char_q  <= res_char;
      ocur_q  <= cursor_d;
      olen_q  <= length_d;
      oview_q <= view_d;
      last_q  <= res_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign line_char_o   = char_q;
  assign cursor_o      = ocur_q;
  assign length_o      = olen_q;
  assign view_offset_o = oview_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

>>> rtl/tle_checker.sv
// ----------------------------------------------------------------------------
// tle_checker: port-level checks of the terminal line editor
// result word consistency and output hold under stall
// ----------------------------------------------------------------------------
`default_nettype none

module tle_checker import tle_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [2:0]       kind_o,
  input wire logic [7:0]       line_char_o,
  input wire logic [CNT_W-1:0] cursor_o,
  input wire logic [CNT_W-1:0] length_o,
  input wire logic [CNT_W-1:0] view_offset_o,
  input wire logic             last_o
);

  // a stalled word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o)
      && $stable(line_char_o) && $stable(last_o))
    else $error("stalled result word changed");

  // only line characters come in multi-word bursts
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_CHAR) |-> last_o && (line_char_o == 8'd0))
    else $error("non-character word not single or carries a character");

  // a finished line leaves an empty line behind
  a_char_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_CHAR) |->
      (cursor_o == '0) && (length_o == '0) && (view_offset_o == '0))
    else $error("character word with non-empty line state");

  // view never passes the cursor, cursor never passes the end
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (view_offset_o <= cursor_o) && (cursor_o <= length_o))
    else $error("view, cursor and length out of order");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .kind_o        (kind_o),
  .line_char_o   (line_char_o),
  .cursor_o      (cursor_o),
  .length_o      (length_o),
  .view_offset_o (view_offset_o),
  .last_o        (last_o)
);

`default_nettype wire
